// ===== design/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants for the complex arithmetic unit
// Opcodes, widths, divider cell transfer type and the output saturation helper.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // exact product width and sum-of-products width
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int SUM_W     = PROD_W + 2;
  // scaled dividend width: |num| << FRAC_BITS plus rounding half
  localparam int DVD_W     = SUM_W + FRAC_BITS;
  // one quotient bit per divider cell
  localparam int DIV_STEPS = WORD_BITS;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // one lane of the restoring divider, handed from cell to cell
  typedef struct packed {
    logic [PROD_W-1:0]    rem;
    logic [DIV_STEPS-1:0] dvd;
    logic [DIV_STEPS-1:0] quo;
    logic [PROD_W-1:0]    den;
  } div_lane_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic                 ovf;
  } sat_t;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // clamp a wide signed value to the word range
  function automatic sat_t sat_word(input logic signed [SUM_W-1:0] v);
    sat_t r;
    logic [SUM_W-WORD_BITS:0] top;
    top = v[SUM_W-1:WORD_BITS-1];
    if ((&top) || !(|top)) begin
      r.val = v[WORD_BITS-1:0];
      r.ovf = 1'b0;
    end else begin
      r.val = v[SUM_W-1] ? WORD_MIN : WORD_MAX;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== design/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// cau_div_cell: one restoring division step
// Shifts in one dividend bit, trial-subtracts the divisor, emits a quotient bit.
// ----------------------------------------------------------------------------
module cau_div_cell import cau_pkg::*; (
  input  logic      clk,
  input  div_lane_t lane_in,
  output div_lane_t lane_out
);

  logic [PROD_W:0] trial;
  logic [PROD_W:0] diff;
  logic            fits;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {lane_in.rem, lane_in.dvd[DIV_STEPS-1]};
    diff  = trial - {1'b0, lane_in.den};
    fits  = trial >= {1'b0, lane_in.den};
  end

  always_ff @(posedge clk) begin
    lane_out.rem <= fits ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
    lane_out.dvd <= {lane_in.dvd[DIV_STEPS-2:0], 1'b0};
    lane_out.quo <= {lane_in.quo[DIV_STEPS-2:0], fits};
    lane_out.den <= lane_in.den;
  end

endmodule

// ===== design/cau_div_row.sv =====
// ----------------------------------------------------------------------------
// cau_div_row: chain of divider cells for one quotient lane
// Each cell resolves one quotient bit, most significant first.
// ----------------------------------------------------------------------------
module cau_div_row import cau_pkg::*; (
  input  logic      clk,
  input  div_lane_t lane_in,
  output div_lane_t lane_out
);

  div_lane_t link [DIV_STEPS+1];

  assign link[0]  = lane_in;
  assign lane_out = link[DIV_STEPS];

  // cells hand the partial remainder on every cycle
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk      (clk),
      .lane_in  (link[i]),
      .lane_out (link[i+1])
    );
  end

endmodule

// ===== design/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex add, subtract, multiply, divide
// Signed fixed point operands, rounded and saturated results.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  input   | start, busy            | opcode, a_real, a_imag, b_real, b_imag
//  result  | done (one-cycle pulse) | res_real, res_imag, overflow, div_by_zero
//
//  One item accepted per cycle while busy is low; results come out in order,
//  whatever the opcode. Each passes input capture, products, sums, divider
//  setup, the chain of 32 divider cells (one quotient bit per cell) and the
//  output register.
//  busy is high only during reset; synchronous reset empties the pipeline.
//  The receiver cannot stall: done pulses for exactly one cycle per result.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic signed [WORD_BITS-1:0] a_real,
  input  logic signed [WORD_BITS-1:0] a_imag,
  input  logic signed [WORD_BITS-1:0] b_real,
  input  logic signed [WORD_BITS-1:0] b_imag,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] res_real,
  output logic signed [WORD_BITS-1:0] res_imag,
  output logic                        overflow,
  output logic                        div_by_zero
);

  // sideband that travels beside the divider rows
  typedef struct packed {
    logic                 vld;
    logic                 is_div;
    logic                 dz;
    logic [WORD_BITS-1:0] val_r;
    logic [WORD_BITS-1:0] val_i;
    logic                 ovf;
    logic                 big_r;
    logic                 big_i;
    logic                 neg_r;
    logic                 neg_i;
  } side_t;

  assign busy = rst;

  // stage 0: input capture
  logic                        v0;
  op_t                         op0;
  logic signed [WORD_BITS-1:0] ar0, ai0, br0, bi0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op0 <= op_t'(opcode);
      ar0 <= a_real;
      ai0 <= a_imag;
      br0 <= b_real;
      bi0 <= b_imag;
    end
  end

  // stage 1: partial products and plain sums
  logic                     v1;
  op_t                      op1;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [WORD_BITS:0] s_r, s_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    op1  <= op0;
    p_rr <= ar0 * br0;
    p_ii <= ai0 * bi0;
    p_ri <= ar0 * bi0;
    p_ir <= ai0 * br0;
    p_bb <= br0 * br0;
    p_cc <= bi0 * bi0;
    if (op0 == OP_SUB) begin
      s_r <= {ar0[WORD_BITS-1], ar0} - {br0[WORD_BITS-1], br0};
      s_i <= {ai0[WORD_BITS-1], ai0} - {bi0[WORD_BITS-1], bi0};
    end else begin
      s_r <= {ar0[WORD_BITS-1], ar0} + {br0[WORD_BITS-1], br0};
      s_i <= {ai0[WORD_BITS-1], ai0} + {bi0[WORD_BITS-1], bi0};
    end
  end

  // stage 2: sums of products, divisor norm
  logic                      v2;
  op_t                       op2;
  logic signed [SUM_W-1:0]   n_r, n_i;
  logic [PROD_W-1:0]         den2;
  logic signed [WORD_BITS:0] s_r2, s_i2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op2  <= op1;
    s_r2 <= s_r;
    s_i2 <= s_i;
    den2 <= $unsigned(p_bb) + $unsigned(p_cc);
    if (op1 == OP_MUL) begin
      n_r <= SUM_W'(p_rr) - SUM_W'(p_ii);
      n_i <= SUM_W'(p_ri) + SUM_W'(p_ir);
    end else begin
      n_r <= SUM_W'(p_rr) + SUM_W'(p_ii);
      n_i <= SUM_W'(p_ir) - SUM_W'(p_ri);
    end
  end

  // stage 3: rounding and saturation for non-divide ops, divider setup
  logic                    abs_neg_r, abs_neg_i;
  logic [SUM_W-1:0]        mag_r, mag_i;
  logic [DVD_W-1:0]        m_r, m_i;
  logic signed [SUM_W-1:0] rnd_r, rnd_i;
  logic signed [SUM_W-1:0] pick_r, pick_i;
  sat_t                    sat_r, sat_i;
  div_lane_t               lane_r3, lane_i3;

  // sideband delay line; entry 0 is the stage 3 register
  side_t side_q [DIV_STEPS+1];

  always_comb begin
    abs_neg_r = n_r[SUM_W-1];
    abs_neg_i = n_i[SUM_W-1];
    mag_r     = abs_neg_r ? -n_r : n_r;
    mag_i     = abs_neg_i ? -n_i : n_i;
    m_r = (DVD_W'(mag_r) << FRAC_BITS) + DVD_W'(den2 >> 1);
    m_i = (DVD_W'(mag_i) << FRAC_BITS) + DVD_W'(den2 >> 1);
    rnd_r = (n_r + (SUM_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
    rnd_i = (n_i + (SUM_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
    if (op2 == OP_MUL) begin
      pick_r = rnd_r;
      pick_i = rnd_i;
    end else begin
      pick_r = SUM_W'(s_r2);
      pick_i = SUM_W'(s_i2);
    end
    sat_r = sat_word(pick_r);
    sat_i = sat_word(pick_i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_q[0].vld <= 1'b0;
    end else begin
      side_q[0].vld <= v2;
    end
    side_q[0].is_div <= op2 == OP_DIV;
    side_q[0].dz     <= (op2 == OP_DIV) && (den2 == '0);
    side_q[0].val_r  <= sat_r.val;
    side_q[0].val_i  <= sat_i.val;
    side_q[0].ovf    <= sat_r.ovf || sat_i.ovf;
    // quotient needs more than DIV_STEPS bits when the top part reaches den
    side_q[0].big_r  <= PROD_W'(m_r[DVD_W-1:DIV_STEPS]) >= den2;
    side_q[0].big_i  <= PROD_W'(m_i[DVD_W-1:DIV_STEPS]) >= den2;
    side_q[0].neg_r  <= abs_neg_r;
    side_q[0].neg_i  <= abs_neg_i;
    lane_r3.rem  <= PROD_W'(m_r[DVD_W-1:DIV_STEPS]);
    lane_r3.dvd  <= m_r[DIV_STEPS-1:0];
    lane_r3.quo  <= '0;
    lane_r3.den  <= den2;
    lane_i3.rem  <= PROD_W'(m_i[DVD_W-1:DIV_STEPS]);
    lane_i3.dvd  <= m_i[DIV_STEPS-1:0];
    lane_i3.quo  <= '0;
    lane_i3.den  <= den2;
  end

  // divider chains, one per part
  div_lane_t lane_r_out, lane_i_out;

  cau_div_row u_row_r (
    .clk      (clk),
    .lane_in  (lane_r3),
    .lane_out (lane_r_out)
  );

  cau_div_row u_row_i (
    .clk      (clk),
    .lane_in  (lane_i3),
    .lane_out (lane_i_out)
  );

  // sideband delay line matching the divider chains
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[k+1].vld <= 1'b0;
      end else begin
        side_q[k+1].vld <= side_q[k].vld;
      end
      side_q[k+1].is_div <= side_q[k].is_div;
      side_q[k+1].dz     <= side_q[k].dz;
      side_q[k+1].val_r  <= side_q[k].val_r;
      side_q[k+1].val_i  <= side_q[k].val_i;
      side_q[k+1].ovf    <= side_q[k].ovf;
      side_q[k+1].big_r  <= side_q[k].big_r;
      side_q[k+1].big_i  <= side_q[k].big_i;
      side_q[k+1].neg_r  <= side_q[k].neg_r;
      side_q[k+1].neg_i  <= side_q[k].neg_i;
    end
  end

  side_t side_end;
  assign side_end = side_q[DIV_STEPS];

  // signed quotient with saturation
  function automatic sat_t quo_sat(input logic big, input logic neg,
                                   input logic [DIV_STEPS-1:0] q);
    sat_t r;
    if (big) begin
      r.val = neg ? WORD_MIN : WORD_MAX;
      r.ovf = 1'b1;
    end else if (!neg) begin
      r.val = q[DIV_STEPS-1] ? WORD_MAX : q;
      r.ovf = q[DIV_STEPS-1];
    end else if (q > WORD_MIN) begin
      r.val = WORD_MIN;
      r.ovf = 1'b1;
    end else begin
      r.val = -q;
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  sat_t q_r, q_i;

  always_comb begin
    q_r = quo_sat(side_end.big_r, side_end.neg_r, lane_r_out.quo);
    q_i = quo_sat(side_end.big_i, side_end.neg_i, lane_i_out.quo);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    div_by_zero <= side_end.dz;
    if (side_end.dz) begin
      res_real <= '0;
      res_imag <= '0;
      overflow <= 1'b0;
    end else if (side_end.is_div) begin
      res_real <= q_r.val;
      res_imag <= q_i.val;
      overflow <= q_r.ovf || q_i.ovf;
    end else begin
      res_real <= side_end.val_r;
      res_imag <= side_end.val_i;
      overflow <= side_end.ovf;
    end
  end

  // checks
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(overflow && div_by_zero))
    else $error("overflow and divide-by-zero both set");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && div_by_zero |-> res_real == '0 && res_imag == '0)
    else $error("zero divisor gave nonzero result");

  a_dz_only_div: assert property (@(posedge clk) disable iff (rst)
    side_end.vld && !side_end.is_div |-> !side_end.dz)
    else $error("divide-by-zero raised outside divide");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    side_end.vld |=> done)
    else $error("result strobe lost");

endmodule
